### rtl/core/coord_hash_table_linear_probe_unit_defines.svh
// assertion macros shared by the coordinate hash table rtl
`ifndef COORD_HASH_TABLE_LINEAR_PROBE_UNIT_DEFINES_SVH
`define COORD_HASH_TABLE_LINEAR_PROBE_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define CHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash table assertion failed");

// next-cycle implication, held off during reset
`define CHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash table assertion failed");

`endif

### rtl/core/chtlp_pkg.sv
// types, codes and constants of the coordinate hash table
package chtlp_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int SLOTS_DEF         = 512;
  localparam int SLOT_W            = 9;

  localparam logic [31:0] HASH_MUL_X = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_Y = 32'd805459861;
  localparam logic [31:0] HASH_MUL_Z = 32'd1234567891;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_USED  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  typedef struct packed {
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    logic [SLOT_W-1:0] slot;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HOME, S_READ, S_EVAL, S_CHECK,
    S_WIPE, S_SCAN_RD, S_SCAN_EV, S_SCAN_NXT, S_DONE
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic hash;
    logic home;
    logic rd_entry;
    logic advance;
    logic place;
    logic rec_write;
    logic tomb;
    logic tomb_zero;
    logic clr_zero;
    logic clr_inc;
    logic clr_tag;
    logic clr_valid;
    logic scan_zero;
    logic scan_rd;
    logic scan_load;
    logic scan_inc;
    logic res_hit;
    logic res_miss;
    logic res_full;
    logic res_rebuilt;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       tag_empty;
    logic       tag_used;
    logic       key_match;
    logic       step_last;
    logic       clr_last_all;
    logic       clr_last_tab;
    logic       scan_valid;
    logic       scan_last;
    logic       tomb_over;
    logic       out_free;
  } sts_t;

endpackage

### rtl/core/chtlp_ctrl.sv
// sequencer for probing, placing, removing and rebuilding
module chtlp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  chtlp_pkg::sts_t  sts,
  output chtlp_pkg::cmd_t  cmd
);
  import chtlp_pkg::*;

  state_t state, state_next;
  logic   rb, rb_next;
  logic   placing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      rb    <= 1'b0;
    end else begin
      state <= state_next;
      rb    <= rb_next;
    end
  end

  assign placing = rb || (sts.act == ACT_INSERT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    rb_next    = rb;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_tag   = 1'b1;
        cmd.clr_valid = 1'b1;
        cmd.clr_inc   = 1'b1;
        if (sts.clr_last_all) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (!rb && sts.act == ACT_NOP) state_next = S_DONE;
        else state_next = S_HOME;
      end
      S_HOME: begin
        cmd.home   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd_entry = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        if (placing) begin
          if (!sts.tag_used) begin
            cmd.place     = 1'b1;
            cmd.rec_write = !rb;
            state_next    = rb ? S_SCAN_NXT : S_DONE;
          end else if (sts.step_last) begin
            cmd.res_full = !rb;
            state_next   = rb ? S_SCAN_NXT : S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          if (sts.tag_empty) begin
            cmd.res_miss = 1'b1;
            state_next   = S_DONE;
          end else if (sts.tag_used && sts.key_match) begin
            cmd.res_hit = 1'b1;
            if (sts.act == ACT_REMOVE) begin
              cmd.tomb   = 1'b1;
              state_next = S_CHECK;
            end else begin
              state_next = S_DONE;
            end
          end else if (sts.step_last) begin
            cmd.res_miss = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_CHECK: begin
        if (sts.tomb_over) begin
          cmd.res_rebuilt = 1'b1;
          cmd.tomb_zero   = 1'b1;
          cmd.clr_zero    = 1'b1;
          cmd.scan_zero   = 1'b1;
          rb_next         = 1'b1;
          state_next      = S_WIPE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WIPE: begin
        cmd.clr_tag = 1'b1;
        cmd.clr_inc = 1'b1;
        if (sts.clr_last_tab) state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (sts.scan_valid) begin
          cmd.scan_load = 1'b1;
          state_next    = S_HASH;
        end else begin
          state_next = S_SCAN_NXT;
        end
      end
      S_SCAN_NXT: begin
        if (sts.scan_last) begin
          rb_next    = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

### rtl/core/chtlp_dp.sv
// datapath: hash, entry and slot memories, probe and sweep counters, result register
module chtlp_dp #(
  parameter int TABLE_ENTRIES = chtlp_pkg::TABLE_ENTRIES_DEF,
  parameter int SLOTS         = chtlp_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  chtlp_pkg::cmd_t    cmd,
  output chtlp_pkg::sts_t    sts,
  input  logic [1:0]         action,
  input  logic signed [31:0] key_x,
  input  logic signed [31:0] key_y,
  input  logic signed [31:0] key_z,
  input  logic [8:0]         slot_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [8:0]         slot_out,
  output logic [1:0]         status,
  output logic               rebuilt
);
  import chtlp_pkg::*;

  localparam int TW    = $clog2(TABLE_ENTRIES);
  localparam int SW    = $clog2(SLOTS);
  localparam int CLR_N = (TABLE_ENTRIES > SLOTS) ? TABLE_ENTRIES : SLOTS;
  localparam int CW    = $clog2(CLR_N);

  logic [31:0]       kx, ky, kz;
  logic [1:0]        act;
  logic [SLOT_W-1:0] ins_slot;
  logic [31:0]       px, py, pz;
  logic [TW-1:0]     idx, step;
  logic [1:0]        tag_rd;
  ent_t              ent_rd;
  logic [TW:0]       tomb_cnt;
  logic [CW-1:0]     clr_cnt;
  logic [SW-1:0]     scan;
  logic              sv_rd;
  logic [95:0]       sk_rd;
  logic              res_found, res_rebuilt;
  logic [SLOT_W-1:0] res_slot;
  logic [1:0]        res_status;

  logic [1:0] tag_mem   [TABLE_ENTRIES];
  ent_t       ent_mem   [TABLE_ENTRIES];
  logic       valid_mem [SLOTS];
  logic [95:0] key_mem  [SLOTS];

  logic          clr_in_tab, clr_in_slots, slot_ok, rm_ok;
  logic          tag_we, val_we, val_wd;
  logic [TW-1:0] tag_wa;
  logic [1:0]    tag_wd;
  logic [SW-1:0] val_wa;

  assign clr_in_tab   = {1'b0, clr_cnt} < (CW+1)'(TABLE_ENTRIES);
  assign clr_in_slots = {1'b0, clr_cnt} < (CW+1)'(SLOTS);
  assign slot_ok      = 32'(ins_slot) < 32'(SLOTS);
  assign rm_ok        = 32'(ent_rd.slot) < 32'(SLOTS);

  assign tag_we = cmd.place || cmd.tomb || (cmd.clr_tag && clr_in_tab);
  assign tag_wa = cmd.clr_tag ? clr_cnt[TW-1:0] : idx;
  assign tag_wd = cmd.place ? TAG_USED : (cmd.tomb ? TAG_TOMB : TAG_EMPTY);

  assign val_we = (cmd.rec_write && slot_ok) || (cmd.tomb && rm_ok)
                  || (cmd.clr_valid && clr_in_slots);
  assign val_wa = cmd.clr_valid ? clr_cnt[SW-1:0]
                : (cmd.rec_write ? SW'(ins_slot) : SW'(ent_rd.slot));
  assign val_wd = cmd.rec_write;

  // entry memories
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (cmd.place) ent_mem[idx] <= '{x: kx, y: ky, z: kz, slot: ins_slot};
    if (cmd.rd_entry) begin
      tag_rd <= tag_mem[idx];
      ent_rd <= ent_mem[idx];
    end
  end

  // slot record memories
  always_ff @(posedge clk) begin
    if (val_we) valid_mem[val_wa] <= val_wd;
    if (cmd.rec_write && slot_ok) key_mem[SW'(ins_slot)] <= {kx, ky, kz};
    if (cmd.scan_rd) begin
      sv_rd <= valid_mem[scan];
      sk_rd <= key_mem[scan];
    end
  end

  // key, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kx       <= key_x;
      ky       <= key_y;
      kz       <= key_z;
      act      <= action;
      ins_slot <= slot_number;
    end else if (cmd.scan_load) begin
      kx       <= sk_rd[95:64];
      ky       <= sk_rd[63:32];
      kz       <= sk_rd[31:0];
      ins_slot <= SLOT_W'(scan);
    end
    if (cmd.hash) begin
      px <= kx * HASH_MUL_X;
      py <= ky * HASH_MUL_Y;
      pz <= kz * HASH_MUL_Z;
    end
    if (cmd.home) begin
      idx  <= TW'(px ^ py ^ pz);
      step <= '0;
    end else if (cmd.advance) begin
      idx  <= idx + 1'b1;
      step <= step + 1'b1;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tomb_cnt <= '0;
      clr_cnt  <= '0;
      scan     <= '0;
    end else begin
      if (cmd.tomb_zero) tomb_cnt <= '0;
      else if (cmd.tomb) tomb_cnt <= tomb_cnt + 1'b1;
      else if (cmd.place && tag_rd == TAG_TOMB && tomb_cnt != '0)
        tomb_cnt <= tomb_cnt - 1'b1;
      if (cmd.clr_zero) clr_cnt <= '0;
      else if (cmd.clr_inc) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.scan_zero) scan <= '0;
      else if (cmd.scan_inc) scan <= scan + 1'b1;
    end
  end

  // result being built
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      res_found   <= 1'b0;
      res_slot    <= '0;
      res_status  <= ST_DONE;
      res_rebuilt <= 1'b0;
    end else begin
      if (cmd.res_hit) begin
        res_found <= 1'b1;
        res_slot  <= ent_rd.slot;
      end
      if (cmd.res_miss) res_status <= ST_MISS;
      if (cmd.res_full) res_status <= ST_FULL;
      if (cmd.res_rebuilt) res_rebuilt <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found    <= res_found;
      slot_out <= res_slot;
      status   <= res_status;
      rebuilt  <= res_rebuilt;
    end
  end

  always_comb begin
    sts.act          = act;
    sts.tag_empty    = (tag_rd == TAG_EMPTY);
    sts.tag_used     = (tag_rd == TAG_USED);
    sts.key_match    = (ent_rd.x == kx) && (ent_rd.y == ky) && (ent_rd.z == kz);
    sts.step_last    = (step == TW'(TABLE_ENTRIES - 1));
    sts.clr_last_all = (clr_cnt == CW'(CLR_N - 1));
    sts.clr_last_tab = (clr_cnt == CW'(TABLE_ENTRIES - 1));
    sts.scan_valid   = sv_rd;
    sts.scan_last    = (scan == SW'(SLOTS - 1));
    sts.tomb_over    = (tomb_cnt > (TW+1)'(TABLE_ENTRIES / 4));
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

### rtl/core/coord_hash_table_linear_probe_unit.sv
// top level of the coordinate hash table with linear probing and tombstones
// sequence: a word is taken in IDLE, then HASH, HOME, READ and EVAL, with READ and EVAL again
// per further probe, CHECK after a remove that hits, then DONE; a no-op goes from HASH to DONE
// one word in flight: the next word is taken only after DONE has loaded the result register
// rebuild: the tags of all TABLE_ENTRIES entries are wiped, then each valid slot record is placed anew
// reset: a clearing pass over max(TABLE_ENTRIES, SLOTS) entries, no word taken meanwhile
`include "coord_hash_table_linear_probe_unit_defines.svh"

module coord_hash_table_linear_probe_unit #(
  parameter int TABLE_ENTRIES = chtlp_pkg::TABLE_ENTRIES_DEF,
  parameter int SLOTS         = chtlp_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] key_x,
  input  logic signed [31:0] key_y,
  input  logic signed [31:0] key_z,
  input  logic [8:0]         slot_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [8:0]         slot_out,
  output logic [1:0]         status,
  output logic               rebuilt
);
  import chtlp_pkg::*;

  // command and status bundles between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, probe loop, tombstone rebuild, result hand-off
  chtlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: hash products, entry table, slot records, output register
  chtlp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SLOTS         (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (action),
    .key_x       (key_x),
    .key_y       (key_y),
    .key_z       (key_z),
    .slot_number (slot_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .slot_out    (slot_out),
    .status      (status),
    .rebuilt     (rebuilt)
  );

  // tombstones never stay above the limit once a word is finished
  `CHT_ASSERT_IMP(a_idle_tomb, in_ready, !sts.tomb_over)
  // the result register is only reloaded when it is free
  `CHT_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free)
  // a loaded result is shown in the next cycle
  `CHT_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid)
  // a rebuild only follows a successful remove
  `CHT_ASSERT_IMP(a_rebuilt_found, out_valid && rebuilt, found && (status == ST_DONE))

endmodule

### dv/testbench.sv
// self-checking testbench of the coordinate hash table with linear probing
`timescale 1ns / 1ps

module testbench;
  import chtlp_pkg::*;

  localparam int TBL = 1024;
  localparam int NSLOT = 512;
  localparam int STALL_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] x, y, z;
    logic [8:0]  slot;
    bit          drain;   // hold the word back until every result has come
  } word_t;

  typedef struct packed {
    logic       found;
    logic [8:0] slot;
    logic [1:0] status;
    logic       rebuilt;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] action = ACT_NOP;
  logic signed [31:0] key_x = 0, key_y = 0, key_z = 0;
  logic [8:0] slot_number = 0;
  logic out_valid;
  logic out_ready = 0;
  logic found;
  logic [8:0] slot_out;
  logic [1:0] status;
  logic rebuilt;

  coord_hash_table_linear_probe_unit dut (.*);

  // words waiting to be offered, and results still owed by the block
  word_t word_q[$];
  res_t  owed_q[$];
  int    n_words;
  int    words_taken = 0;
  int    results_seen = 0;
  int    err_cnt = 0;

  // shadow copy of the table
  logic [1:0]  sh_tag[TBL];
  logic [31:0] sh_x[TBL], sh_y[TBL], sh_z[TBL];
  logic [8:0]  sh_slot[TBL];
  logic [95:0] rec_key[NSLOT];
  bit          rec_valid[NSLOT];
  int          tomb_cnt;

  initial forever #1 clk = ~clk;

  function automatic int home_entry(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] h;
    h = (x * HASH_MUL_X) ^ (y * HASH_MUL_Y) ^ (z * HASH_MUL_Z);
    return int'(h & (TBL - 1));
  endfunction

  // used entry holding the key, or -1; stops at the first empty entry
  function automatic int find_entry(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int h, p;
    h = home_entry(x, y, z);
    for (int i = 0; i < TBL; i++) begin
      p = (h + i) & (TBL - 1);
      if (sh_tag[p] == TAG_EMPTY) return -1;
      if (sh_tag[p] == TAG_USED && sh_x[p] == x && sh_y[p] == y && sh_z[p] == z)
        return p;
    end
    return -1;
  endfunction

  // first empty or tombstone entry takes the key
  function automatic bit place_key(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [8:0] s);
    int h, p;
    h = home_entry(x, y, z);
    for (int i = 0; i < TBL; i++) begin
      p = (h + i) & (TBL - 1);
      if (sh_tag[p] != TAG_USED) begin
        if (sh_tag[p] == TAG_TOMB && tomb_cnt > 0) tomb_cnt--;
        sh_tag[p] = TAG_USED;
        sh_x[p] = x;
        sh_y[p] = y;
        sh_z[p] = z;
        sh_slot[p] = s;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic res_t table_step(word_t w);
    res_t r;
    int p;
    r = '0;
    if (w.act == ACT_LOOKUP || w.act == ACT_REMOVE) begin
      p = find_entry(w.x, w.y, w.z);
      if (p < 0) r.status = ST_MISS;
      else begin
        r.found = 1;
        r.slot = sh_slot[p];
        if (w.act == ACT_REMOVE) begin
          sh_tag[p] = TAG_TOMB;
          tomb_cnt++;
          // removed slot is dropped before any rebuild
          rec_valid[r.slot] = 0;
          if (tomb_cnt > TBL / 4) begin
            for (int i = 0; i < TBL; i++) sh_tag[i] = TAG_EMPTY;
            tomb_cnt = 0;
            for (int s = 0; s < NSLOT; s++)
              if (rec_valid[s])
                void'(place_key(rec_key[s][95:64], rec_key[s][63:32], rec_key[s][31:0],
                                9'(s)));
            r.rebuilt = 1;
          end
        end
      end
    end else if (w.act == ACT_INSERT) begin
      if (place_key(w.x, w.y, w.z, w.slot)) begin
        rec_key[w.slot] = {w.x, w.y, w.z};
        rec_valid[w.slot] = 1;
      end else r.status = ST_FULL;
    end
    return r;
  endfunction

  function automatic void add_word(logic [1:0] a, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic [8:0] s, bit d = 0);
    word_t w;
    w.act = a; w.x = x; w.y = y; w.z = z; w.slot = s; w.drain = d;
    word_q.push_back(w);
  endfunction

  // idle percentage per side: sender 38 / receiver 87, then swapped, then none
  function automatic int tx_idle_pct();
    if (words_taken < n_words / 3) return 38;
    if (words_taken < 2 * n_words / 3) return 87;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (words_taken < n_words / 3) return 87;
    if (words_taken < 2 * n_words / 3) return 38;
    return 0;
  endfunction

  // mixed traffic over a small pool of keys so that hits and removes are common
  task automatic add_mixed(int n, bit first_drain);
    logic [31:0] px[40], py[40], pz[40];
    int k, sel;
    logic [1:0] a;
    for (int i = 0; i < 40; i++) begin
      px[i] = $urandom; py[i] = $urandom; pz[i] = $urandom;
      if (i < 4) begin
        // a few small keys near the origin
        px[i] = 32'($signed($urandom_range(6)) - 3);
        py[i] = 32'($signed($urandom_range(6)) - 3);
        pz[i] = 32'($signed($urandom_range(6)) - 3);
      end
    end
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      a = sel < 30 ? ACT_LOOKUP : sel < 65 ? ACT_INSERT : sel < 95 ? ACT_REMOVE : ACT_NOP;
      k = $urandom_range(39);
      if ($urandom_range(99) < 85)
        add_word(a, px[k], py[k], pz[k], 9'($urandom), first_drain && i == 0);
      else
        add_word(a, $urandom, $urandom, $urandom, 9'($urandom), first_drain && i == 0);
    end
  endtask

  // stimulus
  initial begin
    logic [31:0] fx[$], fy[$], fz[$];
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    for (int i = 0; i < TBL; i++) sh_tag[i] = TAG_EMPTY;
    for (int s = 0; s < NSLOT; s++) rec_valid[s] = 0;
    tomb_cnt = 0;

    // directed: extremes, every action, duplicates, misses, no operation
    add_word(ACT_LOOKUP, 0, 0, 0, 0);
    add_word(ACT_INSERT, 0, 0, 0, 0);
    add_word(ACT_LOOKUP, 0, 0, 0, 9'h1ff);
    add_word(ACT_INSERT, mn, mx, '1, 9'h1ff);
    add_word(ACT_INSERT, mx, mn, 0, 9'h155);
    add_word(ACT_INSERT, '1, '1, '1, 9'h0aa);
    add_word(ACT_LOOKUP, mn, mx, '1, 0);
    add_word(ACT_LOOKUP, '1, '1, '1, 0);
    add_word(ACT_INSERT, mn, mx, '1, 9'd7);      // duplicate key, second entry
    add_word(ACT_LOOKUP, mn, mx, '1, 0);
    add_word(ACT_REMOVE, mn, mx, '1, 0);
    add_word(ACT_LOOKUP, mn, mx, '1, 0);         // second copy now visible
    add_word(ACT_REMOVE, mn, mx, '1, 0);
    add_word(ACT_REMOVE, mn, mx, '1, 0);         // remove of a missing key
    add_word(ACT_LOOKUP, mn, mx, '1, 0);
    add_word(ACT_NOP, '1, '1, '1, 9'h1ff);
    add_word(ACT_NOP, 0, 0, 0, 0);
    add_word(ACT_INSERT, mn, mn, mn, 9'h100);    // same home entry as the zero key, so it probes on
    add_word(ACT_LOOKUP, mx, mn, 0, 0);
    add_word(ACT_REMOVE, 0, 0, 0, 0);

    add_mixed(80, 1);

    // load the table, then remove enough to force a rebuild
    for (int i = 0; i < 270; i++) begin
      fx.push_back($urandom); fy.push_back($urandom); fz.push_back($urandom);
      add_word(ACT_INSERT, fx[i], fy[i], fz[i], 9'(i), i == 0);
    end
    add_word(ACT_LOOKUP, $urandom, $urandom, $urandom, 0);   // miss on a loaded table
    for (int i = 0; i < 260; i++)
      add_word(ACT_REMOVE, fx[i], fy[i], fz[i], 0);
    for (int i = 0; i < 20; i++)
      add_word(ACT_LOOKUP, fx[250 + i], fy[250 + i], fz[250 + i], 0);

    add_mixed(50, 1);
    n_words = word_q.size();

    repeat (5) @(posedge clk);
    rst <= 0;

    wait (word_q.size() == 0 && !in_valid && owed_q.size() == 0);
    repeat (30) @(posedge clk);
    if (err_cnt == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // driver: predicts on acceptance, then offers the next word or idles
  always @(posedge clk) begin
    logic nv;
    word_t w;
    if (rst) begin
      in_valid <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        w.act = action; w.x = key_x; w.y = key_y; w.z = key_z;
        w.slot = slot_number; w.drain = 0;
        owed_q.push_back(table_step(w));
        words_taken++;
        nv = 0;
      end
      if (!nv && word_q.size() > 0 && !(word_q[0].drain && owed_q.size() != 0) &&
          $urandom_range(99) >= tx_idle_pct()) begin
        w = word_q.pop_front();
        action <= w.act;
        key_x <= w.x;
        key_y <= w.y;
        key_z <= w.z;
        slot_number <= w.slot;
        nv = 1;
      end
      in_valid <= nv;
    end
  end

  // monitor: checks each result word against the oldest owed result
  int hold_cnt = 0;
  bit held = 0;

  always @(posedge clk) begin
    res_t e;
    logic rdy;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result word with none owed: found=%0b slot=%0d status=%0d rebuilt=%0b",
                   $time, found, slot_out, status, rebuilt);
        end else begin
          e = owed_q.pop_front();
          if (found !== e.found) begin
            err_cnt++;
            $display("%0t: found expected %0b got %0b", $time, e.found, found);
          end
          if (slot_out !== e.slot) begin
            err_cnt++;
            $display("%0t: slot_out expected %0d got %0d", $time, e.slot, slot_out);
          end
          if (status !== e.status) begin
            err_cnt++;
            $display("%0t: status expected %0d got %0d", $time, e.status, status);
          end
          if (rebuilt !== e.rebuilt) begin
            err_cnt++;
            $display("%0t: rebuilt expected %0b got %0b", $time, e.rebuilt, rebuilt);
          end
        end
      end
      // one long hold-off early on so that the block backs up its input
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 0;
      end else if (results_seen == 30 && !held) begin
        held = 1;
        hold_cnt = 400;
        rdy = 0;
      end else begin
        rdy = $urandom_range(99) >= rx_idle_pct();
      end
      out_ready <= rdy;
    end
  end

  // watchdog on cycles with no word moving on either side
  int quiet_cnt = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/chtlp_pkg.sv
rtl/core/chtlp_ctrl.sv
rtl/core/chtlp_dp.sv
rtl/core/coord_hash_table_linear_probe_unit.sv
dv/testbench.sv
